// ===== rtl/srec_pkg.sv =====
// ----------------------------------------------------------------------------
// srec_pkg
// Shared constants, types and helpers of the S-record line encoder.
// ----------------------------------------------------------------------------
package srec_pkg;

	// Default record length in data bytes
	localparam int unsigned RECORD_BYTES_DEF = 16;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BYTES  = 2'd1;

	// Byte values and address limits
	localparam logic [7:0]  BLANK_BYTE = 8'hFF;
	localparam logic [31:0] S2_LIMIT   = 32'h0001_0000;
	localparam logic [31:0] S3_LIMIT   = 32'h0100_0000;

	// ASCII codes
	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_NL   = 8'h0A;

	// Line formatter sequence
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_S,
		ST_TYPE,
		ST_COUNT,
		ST_ADDR,
		ST_DATA,
		ST_SUM,
		ST_NL
	} fmt_state_t;

	// Record handed from the input side to the formatter
	typedef struct packed {
		logic [31:0] addr;    // address of the first data byte
		logic [7:0]  nbytes;  // data bytes held in the store
		logic [7:0]  dsum;    // low 8 bits of the data byte sum
	} rec_t;

	// Uppercase hex digit
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] w;
		w = {4'h0, v};
		if (v < 4'd10) begin
			hex_char = CH_ZERO + w;
		end else begin
			hex_char = CH_A + (w - 8'd10);
		end
	endfunction

endpackage

// ===== rtl/srec_record_encoder.sv =====
// ----------------------------------------------------------------------------
// srec_record_encoder
// Packs a byte stream into aligned records and sends each record that is
// not all 0xFF as one ASCII S1/S2/S3 line.
// ----------------------------------------------------------------------------
//
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+-----------------------------
// s_axis   | in  | s_axis_tvalid/tready      | tdata[7:0] = data_byte
// m_axis   | out | m_axis_tvalid/tready      | tdata[7:0] = text_char,
//          |     |                           | tlast = line_end
// cfg      | in  | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// A data byte is taken while no line is being sent. A line of a record
// with N data bytes and A address bytes has 2N + 2A + 7 characters, sent
// one character per cycle from the formatter; input waits for it. A write
// to the base address or total bytes register restarts the stream and
// holds input off while the base address residue settles. Reset needs no
// clearing pass. Output stalls hold the formatter and thus the input side.
//
module srec_record_encoder #(
	parameter int unsigned RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [srec_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data,
	// input bytes
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,   // [7:0] data_byte
	// output text
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [7:0]                       m_axis_tdata,   // [7:0] text_char
	output logic                             m_axis_tlast    // line_end
);
	import srec_pkg::*;

	localparam int unsigned IDX_W  = $clog2(RECORD_BYTES);
	localparam int unsigned FILL_W = $clog2(RECORD_BYTES + 1);

	logic [31:0]       base_q;
	logic [31:0]       total_q;
	logic [31:0]       next_addr_q;
	logic [31:0]       left_q;
	logic [31:0]       rec_addr_q;
	logic [FILL_W-1:0] fill_q;
	logic              blank_q;
	logic [7:0]        dsum_q;

	logic              cfg_wr;
	logic              restart;
	logic [31:0]       base_n;
	logic [31:0]       total_n;
	logic              acc;
	logic              take;
	logic              first;
	logic [31:0]       raddr;
	logic [FILL_W-1:0] fill_n;
	logic              blank_n;
	logic [7:0]        dsum_n;
	logic              rec_end;
	logic              launch;
	rec_t              rec;

	logic              res_busy;
	logic              bound;
	logic              fmt_busy;
	logic [IDX_W-1:0]  rd_addr;
	logic [7:0]        rd_data;

	// configuration decode
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign restart   = cfg_wr &&
		(cfg_index == REG_BASE_ADDRESS || cfg_index == REG_TOTAL_BYTES);
	assign base_n    = (cfg_index == REG_BASE_ADDRESS) ? cfg_data : base_q;
	assign total_n   = (cfg_index == REG_TOTAL_BYTES) ? cfg_data : total_q;

	// input acceptance
	assign s_axis_tready = !res_busy && !fmt_busy;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign take          = acc && (left_q != 32'd0) && !restart;

	// record bookkeeping for the accepted byte
	always_comb begin
		first   = (fill_q == '0);
		raddr   = first ? next_addr_q : rec_addr_q;
		fill_n  = fill_q + FILL_W'(1);
		blank_n = (first || blank_q) && (s_axis_tdata == BLANK_BYTE);
		dsum_n  = (first ? 8'd0 : dsum_q) + s_axis_tdata;
		rec_end = (left_q == 32'd1) || bound || (fill_n == FILL_W'(RECORD_BYTES));
		launch  = take && rec_end && !blank_n;
		rec.addr   = raddr;
		rec.nbytes = 8'(fill_n);
		rec.dsum   = dsum_n;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			total_q     <= '0;
			next_addr_q <= '0;
			left_q      <= '0;
			fill_q      <= '0;
			blank_q     <= 1'b1;
		end else if (restart) begin
			base_q      <= base_n;
			total_q     <= total_n;
			next_addr_q <= base_n;
			left_q      <= total_n;
			fill_q      <= '0;
			blank_q     <= 1'b1;
		end else if (take) begin
			next_addr_q <= next_addr_q + 32'd1;
			left_q      <= left_q - 32'd1;
			if (rec_end) begin
				fill_q  <= '0;
				blank_q <= 1'b1;
			end else begin
				fill_q  <= fill_n;
				blank_q <= blank_n;
			end
		end
	end

	// record payload
	always_ff @(posedge clk) begin
		if (take) begin
			rec_addr_q <= raddr;
			dsum_q     <= dsum_n;
		end
	end

	srec_resid #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_resid (
		.clk    (clk),
		.arst_n (arst_n),
		.restart(restart),
		.base   (base_n),
		.step   (take),
		.wrap   (next_addr_q == 32'hFFFF_FFFF),
		.busy   (res_busy),
		.bound  (bound)
	);

	srec_store #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_store (
		.clk  (clk),
		.we   (take),
		.waddr(fill_q[IDX_W-1:0]),
		.wdata(s_axis_tdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	srec_fmt #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_fmt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (launch),
		.rec      (rec),
		.busy     (fmt_busy),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_char (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule

// ===== rtl/srec_store.sv =====
// ----------------------------------------------------------------------------
// srec_store
// Record byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srec_store #(
	parameter int unsigned RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [$clog2(RECORD_BYTES)-1:0] waddr,
	input  logic [7:0]                      wdata,
	input  logic [$clog2(RECORD_BYTES)-1:0] raddr,
	output logic [7:0]                      rdata
);
	import srec_pkg::*;

	logic [7:0] mem_q [RECORD_BYTES];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/srec_resid.sv =====
// ----------------------------------------------------------------------------
// srec_resid
// Tracks the next byte address modulo RECORD_BYTES. On restart the base
// address is folded by nibble weights, then reduced by a reciprocal multiply
// in the following cycle.
// ----------------------------------------------------------------------------
module srec_resid #(
	parameter int unsigned RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        restart,
	input  logic [31:0] base,
	input  logic        step,
	input  logic        wrap,
	output logic        busy,
	output logic        bound
);
	import srec_pkg::*;

	localparam int unsigned RES_W = $clog2(RECORD_BYTES);

	// weight of each address nibble, 16^i modulo RECORD_BYTES
	localparam int unsigned W0 = 1 % RECORD_BYTES;
	localparam int unsigned W1 = 16 % RECORD_BYTES;
	localparam int unsigned W2 = (W1 * 16) % RECORD_BYTES;
	localparam int unsigned W3 = (W2 * 16) % RECORD_BYTES;
	localparam int unsigned W4 = (W3 * 16) % RECORD_BYTES;
	localparam int unsigned W5 = (W4 * 16) % RECORD_BYTES;
	localparam int unsigned W6 = (W5 * 16) % RECORD_BYTES;
	localparam int unsigned W7 = (W6 * 16) % RECORD_BYTES;

	// folded sum stays below 8 * 15 * 15 = 1800
	localparam int unsigned FOLD_W = 11;
	// reciprocal, exact for every folded value
	localparam int unsigned RCP_S  = FOLD_W + RES_W;
	localparam int unsigned RCP_M  = ((1 << RCP_S) + RECORD_BYTES - 1) / RECORD_BYTES;
	localparam int unsigned PROD_W = 2 * FOLD_W + 2;

	logic [RES_W-1:0]  res_q;
	logic              pend_q;
	logic [FOLD_W-1:0] fold_s1;
	logic [FOLD_W-1:0] fold;
	logic [PROD_W-1:0] prod;
	logic [FOLD_W-1:0] quo;
	logic [RES_W-1:0]  res_init;
	logic [RES_W-1:0]  res_nxt;

	// nibble fold of the base address
	always_comb begin
		fold = FOLD_W'(base[3:0]) * FOLD_W'(W0)
			+ FOLD_W'(base[7:4]) * FOLD_W'(W1)
			+ FOLD_W'(base[11:8]) * FOLD_W'(W2)
			+ FOLD_W'(base[15:12]) * FOLD_W'(W3)
			+ FOLD_W'(base[19:16]) * FOLD_W'(W4)
			+ FOLD_W'(base[23:20]) * FOLD_W'(W5)
			+ FOLD_W'(base[27:24]) * FOLD_W'(W6)
			+ FOLD_W'(base[31:28]) * FOLD_W'(W7);
	end

	// remainder of the folded sum
	always_comb begin
		prod     = PROD_W'(fold_s1) * PROD_W'(RCP_M);
		quo      = FOLD_W'(prod >> RCP_S);
		res_init = RES_W'(fold_s1 - quo * FOLD_W'(RECORD_BYTES));
	end

	// residue after one more byte; the 2^32 wrap lands on a boundary
	always_comb begin
		if (wrap || res_q == RES_W'(RECORD_BYTES - 1)) begin
			res_nxt = '0;
		end else begin
			res_nxt = res_q + RES_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q  <= '0;
			pend_q <= 1'b0;
		end else if (restart) begin
			res_q  <= '0;
			pend_q <= 1'b1;
		end else if (pend_q) begin
			res_q  <= res_init;
			pend_q <= 1'b0;
		end else if (step) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (restart) begin
			fold_s1 <= fold;
		end
	end

	assign busy  = pend_q;
	assign bound = (res_nxt == '0);

endmodule

// ===== rtl/srec_fmt.sv =====
// ----------------------------------------------------------------------------
// srec_fmt
// Line formatter: walks one record and sends its S-record text through an
// output register, one character per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module srec_fmt #(
	parameter int unsigned RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  srec_pkg::rec_t                  rec,
	output logic                            busy,
	output logic [$clog2(RECORD_BYTES)-1:0] rd_addr,
	input  logic [7:0]                      rd_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_char,
	output logic                            out_last
);
	import srec_pkg::*;

	localparam int unsigned IDX_W = $clog2(RECORD_BYTES);

	fmt_state_t       state_q, state_d;
	logic [31:0]      addr_q;
	logic [7:0]       nbytes_q;
	logic [7:0]       dsum_q;
	logic [7:0]       cks_q;
	logic [2:0]       nib_q, nib_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             out_last_q;

	logic             load;
	logic             emit;
	logic [7:0]       char_d;
	logic             last_d;
	logic [2:0]       abytes;
	logic [7:0]       count;
	logic [2:0]       last_nib;
	logic [2:0]       apos;
	logic [3:0]       anib;
	logic [7:0]       cks_calc;

	// record type, byte count, address digit and checksum
	always_comb begin
		if (addr_q < S2_LIMIT) begin
			abytes = 3'd2;
		end else if (addr_q < S3_LIMIT) begin
			abytes = 3'd3;
		end else begin
			abytes = 3'd4;
		end
		count    = nbytes_q + 8'(abytes) + 8'd1;
		last_nib = 3'({abytes, 1'b0} - 4'd1);
		apos     = last_nib - nib_q;
		anib     = addr_q[{apos, 2'b00} +: 4];
		cks_calc = ~(count + addr_q[31:24] + addr_q[23:16] + addr_q[15:8]
			+ addr_q[7:0] + dsum_q);
	end

	assign load = !out_valid_q || out_ready;

	// next state and character
	always_comb begin
		state_d = state_q;
		nib_d   = nib_q;
		idx_d   = idx_q;
		char_d  = CH_NL;
		last_d  = 1'b0;
		emit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_S;
				end
			end
			ST_S: begin
				emit   = 1'b1;
				char_d = CH_S;
				if (load) begin
					state_d = ST_TYPE;
				end
			end
			ST_TYPE: begin
				emit   = 1'b1;
				char_d = CH_ZERO + 8'(abytes - 3'd1);
				if (load) begin
					state_d = ST_COUNT;
					nib_d   = 3'd0;
				end
			end
			ST_COUNT: begin
				emit   = 1'b1;
				char_d = hex_char(nib_q[0] ? count[3:0] : count[7:4]);
				if (load) begin
					if (nib_q[0]) begin
						state_d = ST_ADDR;
						nib_d   = 3'd0;
					end else begin
						nib_d = nib_q + 3'd1;
					end
				end
			end
			ST_ADDR: begin
				emit   = 1'b1;
				char_d = hex_char(anib);
				if (load) begin
					if (nib_q == last_nib) begin
						state_d = ST_DATA;
						nib_d   = 3'd0;
					end else begin
						nib_d = nib_q + 3'd1;
					end
				end
			end
			ST_DATA: begin
				emit   = 1'b1;
				char_d = hex_char(nib_q[0] ? rd_data[3:0] : rd_data[7:4]);
				if (load) begin
					if (nib_q[0]) begin
						nib_d = 3'd0;
						if (8'(idx_q) == nbytes_q - 8'd1) begin
							state_d = ST_SUM;
							idx_d   = '0;
						end else begin
							idx_d = idx_q + IDX_W'(1);
						end
					end else begin
						nib_d = 3'd1;
					end
				end
			end
			ST_SUM: begin
				emit   = 1'b1;
				char_d = hex_char(nib_q[0] ? cks_q[3:0] : cks_q[7:4]);
				if (load) begin
					if (nib_q[0]) begin
						state_d = ST_NL;
					end else begin
						nib_d = 3'd1;
					end
				end
			end
			ST_NL: begin
				emit   = 1'b1;
				char_d = CH_NL;
				last_d = 1'b1;
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nib_q       <= 3'd0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			nib_q   <= nib_d;
			idx_q   <= idx_d;
			if (emit && load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// record capture, checksum and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			addr_q   <= rec.addr;
			nbytes_q <= rec.nbytes;
			dsum_q   <= rec.dsum;
		end
		if (state_q == ST_S) begin
			cks_q <= cks_calc;
		end
		if (emit && load) begin
			out_char_q <= char_d;
			out_last_q <= last_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign rd_addr   = idx_d;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

// ===== rtl/srec_checker.sv =====
// ----------------------------------------------------------------------------
// srec_checker
// Port-level checks of the S-record encoder, bound to the top level.
// ----------------------------------------------------------------------------
module srec_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic [7:0] s_axis_tdata,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);
	import srec_pkg::*;

	// a waiting input byte holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input request changed while waiting");

	// a stalled character holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output request changed while stalled");

	// every line closes with a newline
	a_last_nl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CH_NL)
		else $error("line end without newline");

	// no newline inside a line
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata != CH_NL)
		else $error("newline not marked as line end");

	// a valid character right after a line end is 'S' unless cfg_valid was high
	a_line_open: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tvalid && m_axis_tready && m_axis_tlast) && m_axis_tvalid
			&& !$past(cfg_valid) |-> m_axis_tdata == CH_S)
		else $error("line does not start with S");

endmodule

bind srec_record_encoder srec_checker u_srec_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_valid    (cfg_valid),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
